// ===== design/humidity_temperature_conversion_top_defines.svh =====
// Assertion macros shared by the humidity and temperature conversion RTL.
// Depends on nothing. The including module must have clk and arst_n in scope.
`ifndef HUMIDITY_TEMPERATURE_CONVERSION_TOP_DEFINES_SVH
`define HUMIDITY_TEMPERATURE_CONVERSION_TOP_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define HTC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define HTC_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== design/htc_pkg.sv =====
// Package for the humidity and temperature conversion block: widths, constants, types.
// Depends on nothing; used by the top level and the reciprocal divider.
package htc_pkg;

	// Stream payload widths.
	localparam int unsigned RT_W      = 14;
	localparam int unsigned RH_W      = 12;
	localparam int unsigned S_TDATA_W = 32;
	localparam int unsigned CENTI_W   = 15;
	localparam int unsigned MILLI_W   = 19;
	localparam int unsigned HUM_W     = 16;
	localparam int unsigned M_TDATA_W = 56;
	localparam int unsigned M_TUSER_W = 2;

	// Number of pipeline stages from input register to output register.
	localparam int unsigned NSTG = 8;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SUPPLY_IS_5V = 2'd0,
		REG_SENSOR_IS_V4 = 2'd1
	} reg_idx_t;

	// Temperature offsets in 0.01 C and 0.001 F.
	localparam logic signed [15:0] OFS_C_5V = 16'sd4010;
	localparam logic signed [15:0] OFS_C_LV = 16'sd3966;
	localparam logic signed [19:0] OFS_F_5V = 20'sd40200;
	localparam logic signed [19:0] OFS_F_LV = 20'sd39400;
	localparam logic [4:0]         F_GAIN   = 5'd18;
	localparam logic signed [15:0] T_LO     = -16'sd4000;
	localparam logic signed [15:0] T_HI     = 16'sd12500;
	localparam logic signed [15:0] T_REF    = 16'sd2500;
	localparam logic [12:0]        RH_OFS   = 13'd125;

	// Fahrenheit minus eighteen times Celsius, per supply setting.
	localparam int F_GAP_5V = 31980;
	localparam int F_GAP_LV = 31988;

	// Humidity accumulator, scaled to 5e-10 %RH per unit.
	localparam int unsigned H_W = 41;
	localparam int unsigned C2_W = 27;
	localparam int unsigned C3_W = 13;
	localparam logic signed [H_W-1:0] C1_V3 = -41'sd8000000000;
	localparam logic signed [H_W-1:0] C1_V4 = -41'sd4093600000;
	localparam logic [C2_W-1:0]       C2_V3 = 27'd81000000;
	localparam logic [C2_W-1:0]       C2_V4 = 27'd73400000;
	localparam logic [C3_W-1:0]       C3_V3 = 13'd5600;
	localparam logic [C3_W-1:0]       C3_V4 = 13'd3191;
	localparam logic signed [H_W-1:0] T_GAIN = 41'sd1600;
	localparam logic signed [H_W-1:0] HUM_HI = 41'sd200000000000;

	// Floor division by 2e7: shift by 8, then divide by 78125 through a reciprocal.
	localparam int unsigned H_SHIFT   = 8;
	localparam int unsigned XU_W      = 31;
	localparam int unsigned DIV_SHIFT = 31;
	localparam int unsigned RECIP_W   = 15;
	localparam int unsigned Q0_W      = 15;
	localparam int unsigned R_W       = 18;
	localparam int unsigned PROD_W    = XU_W + RECIP_W;
	localparam logic [R_W-1:0]       DIV_D     = 18'd78125;
	localparam logic [RECIP_W-1:0]   DIV_RECIP = RECIP_W'((64'd1 << DIV_SHIFT) / 64'd78125);
	localparam logic signed [16:0]   DIV_K     = 17'sd2048;
	localparam logic signed [H_W-1:0] DIV_BIAS = 41'sd160000000;

	// Temperature results that travel alongside the humidity computation.
	typedef struct packed {
		logic [CENTI_W-1:0] centi;
		logic [MILLI_W-1:0] milli;
		logic               tvalid;
	} temp_t;

endpackage

// ===== design/htc_recip_div.sv =====
// Three-stage floor division of a biased non-negative value by 78125.
// Depends on htc_pkg; stage loads come from the pipeline control in the top level.
module htc_recip_div (
	input  logic                          clk,
	input  logic [2:0]                    ld,
	input  logic [htc_pkg::XU_W-1:0]      xu,
	output logic signed [htc_pkg::HUM_W-1:0] q
);
	import htc_pkg::*;

	logic [PROD_W-1:0]  prod;
	logic [31:0]        qd;
	logic [31:0]        diff;
	logic signed [16:0] qs;

	logic [XU_W-1:0]    xu_s6;
	logic [Q0_W-1:0]    q0_s6;
	logic [Q0_W-1:0]    q0_s7;
	logic [R_W-1:0]     r_s7;
	logic signed [HUM_W-1:0] q_s8;

	// The estimate is the true quotient or one below it.
	assign prod = PROD_W'(xu) * PROD_W'(DIV_RECIP);
	assign qd   = 32'(q0_s6) * 32'(DIV_D);
	assign diff = 32'(xu_s6) - qd;
	assign qs   = $signed({2'b00, q0_s7}) + ((r_s7 >= DIV_D) ? 17'sd1 : 17'sd0) - DIV_K;

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			xu_s6 <= xu;
			q0_s6 <= prod[PROD_W-1:DIV_SHIFT];
		end
		if (ld[1]) begin
			q0_s7 <= q0_s6;
			r_s7  <= diff[R_W-1:0];
		end
		if (ld[2]) begin
			q_s8 <= qs[HUM_W-1:0];
		end
	end

	assign q = q_s8;

endmodule

// ===== design/humidity_temperature_conversion_top.sv =====
// Top level of the humidity and temperature conversion pipeline.
// Depends on htc_pkg, htc_recip_div and humidity_temperature_conversion_top_defines.svh.
//
// One raw temperature and raw humidity pair enters per transfer on the slave stream and
// one result leaves per transfer on the master stream, in order. The block takes a new
// reading every clock unless a master stall has filled all stages; the pipeline depth is
// set by the chain of multipliers (temperature, products of the humidity polynomial, the
// sum, and a three-stage reciprocal divider that floors to 0.01 %RH). A stall on the
// master side holds every full stage in place while empty stages keep filling, so a
// backed-up output still lets up to eight readings be accepted. Temperature comes out in
// 0.01 C and 0.001 F, humidity in 0.01 %RH floored toward minus infinity, and two flags
// on tuser mark a Celsius value within -40..125 C and an exact humidity within 0..100 %RH.
// The two configuration registers (supply selection and sensor generation) reset to zero
// and are written through the cfg channel, which is always ready; they must only change
// while the pipeline is empty.
module humidity_temperature_conversion_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_index,
	input  logic                            cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// raw_temperature [13:0], raw_humidity [25:14], zero fill above
	input  logic [htc_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// temperature_centi_c [14:0], temperature_milli_f [33:15], humidity_centi_pct [49:34],
	// zero fill above
	output logic [htc_pkg::M_TDATA_W-1:0]   m_tdata,
	// temperature_valid [0], humidity_valid [1]
	output logic [htc_pkg::M_TUSER_W-1:0]   m_tuser
);
	import htc_pkg::*;

	`include "humidity_temperature_conversion_top_defines.svh"

	// Configuration registers.
	logic supply_q;
	logic v4_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 1'b0;
			v4_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SUPPLY_IS_5V: supply_q <= cfg_data;
				REG_SENSOR_IS_V4: v4_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline control: a stage loads when it is empty or its contents move on.
	logic [NSTG:1] vld;
	logic [NSTG:1] ld;
	logic [NSTG:1] vin;

	always_comb begin
		ld[NSTG] = !vld[NSTG] || m_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ld[k] = !vld[k] || ld[k+1];
		end
	end

	assign vin      = {vld[NSTG-1:1], s_tvalid};
	assign s_tready = ld[1];
	assign m_tvalid = vld[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 1; k <= NSTG; k++) begin
				if (ld[k]) begin
					vld[k] <= vin[k];
				end
			end
		end
	end

	// Temperature results ride along with the humidity data. Stage 1 computes them and
	// every later stage passes them on.
	temp_t tmp_s [1:NSTG];

	// Stage 1: temperature conversions.
	logic [RT_W-1:0]    rt;
	logic [RH_W-1:0]    rh_s1;
	logic signed [15:0] centi_w;
	logic [18:0]        rt18;
	logic signed [19:0] milli_w;

	assign rt      = s_tdata[RT_W-1:0];
	assign centi_w = $signed({2'b00, rt}) - (supply_q ? OFS_C_5V : OFS_C_LV);
	assign rt18    = 19'(rt) * 19'(F_GAIN);
	assign milli_w = $signed({1'b0, rt18}) - (supply_q ? OFS_F_5V : OFS_F_LV);

	always_ff @(posedge clk) begin
		if (ld[1]) begin
			rh_s1           <= s_tdata[RT_W+RH_W-1:RT_W];
			tmp_s[1].centi  <= centi_w[CENTI_W-1:0];
			tmp_s[1].milli  <= milli_w[MILLI_W-1:0];
			tmp_s[1].tvalid <= (centi_w >= T_LO) && (centi_w <= T_HI);
		end
		for (int k = 2; k <= NSTG; k++) begin
			if (ld[k]) begin
				tmp_s[k] <= tmp_s[k-1];
			end
		end
	end

	// Stage 2: first-level products of the humidity polynomial.
	logic signed [15:0] tdiff;
	logic [12:0]        rhp;
	logic [C2_W-1:0]    c2_sel;
	logic signed [29:0] tprod_s2;
	logic [38:0]        c2rh_s2;
	logic [23:0]        rhsq_s2;

	assign tdiff  = $signed({tmp_s[1].centi[CENTI_W-1], tmp_s[1].centi}) - T_REF;
	assign rhp    = 13'(rh_s1) + RH_OFS;
	assign c2_sel = v4_q ? C2_V4 : C2_V3;

	always_ff @(posedge clk) begin
		if (ld[2]) begin
			tprod_s2 <= 30'(tdiff) * $signed({17'd0, rhp});
			c2rh_s2  <= 39'(c2_sel) * 39'(rh_s1);
			rhsq_s2  <= 24'(rh_s1) * 24'(rh_s1);
		end
	end

	// Stage 3: quadratic term, temperature correction and the constant plus linear term.
	logic [C3_W-1:0]          c3_sel;
	logic [36:0]              c3p_s3;
	logic signed [H_W-1:0]    t16_s3;
	logic signed [H_W-1:0]    a_s3;

	assign c3_sel = v4_q ? C3_V4 : C3_V3;

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			c3p_s3 <= 37'(c3_sel) * 37'(rhsq_s2);
			t16_s3 <= H_W'(tprod_s2) * T_GAIN;
			a_s3   <= (v4_q ? C1_V4 : C1_V3) + $signed({2'b00, c2rh_s2});
		end
	end

	// Stage 4: exact humidity in units of 5e-10 %RH.
	logic signed [H_W-1:0] h_s4;

	always_ff @(posedge clk) begin
		if (ld[4]) begin
			h_s4 <= a_s3 + t16_s3 - $signed({4'b0000, c3p_s3});
		end
	end

	// Stage 5: range flag, and the floor shift plus bias that makes the dividend positive.
	logic signed [H_W-1:0] hsh;
	logic signed [H_W-1:0] xw;
	logic [XU_W-1:0]       xu_s5;
	logic                  hv_s [5:NSTG];

	assign hsh = h_s4 >>> H_SHIFT;
	assign xw  = hsh + DIV_BIAS;

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			xu_s5   <= xw[XU_W-1:0];
			hv_s[5] <= !h_s4[H_W-1] && (h_s4 <= HUM_HI);
		end
		for (int k = 6; k <= NSTG; k++) begin
			if (ld[k]) begin
				hv_s[k] <= hv_s[k-1];
			end
		end
	end

	// Stages 6 to 8: division by 78125 and removal of the bias.
	logic signed [HUM_W-1:0] hum_q;

	htc_recip_div u_div (
		.clk (clk),
		.ld  (ld[NSTG:6]),
		.xu  (xu_s5),
		.q   (hum_q)
	);

	assign m_tdata = {{(M_TDATA_W - HUM_W - MILLI_W - CENTI_W){1'b0}},
		hum_q, tmp_s[NSTG].milli, tmp_s[NSTG].centi};
	assign m_tuser = {hv_s[NSTG], tmp_s[NSTG].tvalid};

	// The temperature flag must agree with the Celsius value it travels with.
	`HTC_ASSERT_IMP(a_tvalid_match, m_tvalid,
		m_tuser[0] == (($signed(m_tdata[14:0]) >= -4000) && ($signed(m_tdata[14:0]) <= 12500)),
		"temperature flag disagrees with Celsius value")

	// A humidity flagged in range must have floored into 0..100 %RH.
	`HTC_ASSERT_IMP(a_hvalid_range, m_tvalid && m_tuser[1],
		($signed(m_tdata[49:34]) >= 0) && ($signed(m_tdata[49:34]) <= 10000),
		"humidity flagged valid but out of range")

	// Fahrenheit and Celsius come from the same raw reading.
	`HTC_ASSERT_IMP(a_f_c_pair, m_tvalid,
		($signed(m_tdata[33:15]) - 18 * $signed(m_tdata[14:0]) == F_GAP_5V) ||
		($signed(m_tdata[33:15]) - 18 * $signed(m_tdata[14:0]) == F_GAP_LV),
		"Fahrenheit and Celsius results are misaligned")

	// An accepted reading always lands in the first stage.
	`HTC_ASSERT(a_accept_lands, (s_tvalid && s_tready) |=> vld[1], "accepted reading was not captured")

endmodule
